// ===== rtl/mse_pkg.sv =====
// shared constants for the mips subset execute block
`default_nettype none
package mse_pkg;

  // data memory size in words and its address width
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DATA_AW    = $clog2(DATA_WORDS);

  // configuration port
  localparam int unsigned CFG_IW        = 2;
  localparam logic [CFG_IW-1:0] CFG_START_ADDRESS = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_DATA_BASE     = CFG_IW'(1);

  localparam logic [31:0] START_RESET = 32'h0040_0000;
  localparam logic [31:0] BASE_RESET  = 32'h1000_0000;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // function codes of register-format words
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [4:0] LINK_REG = 5'd31;

endpackage
`default_nettype wire

// ===== rtl/mips_subset_execute.sv =====
// mips subset execute: register file, data memory, decode and execute
//
// The block executes one instruction word per input transfer. The outside
// fetches each word at the next_pc of the previous result (start_address
// after reset or after a start_address write) and sends it on the in channel.
// Every accepted word gives exactly one result transfer on the out channel.
// The register file and the data memory are synchronous RAMs: a word's
// operands are read at the edge it is accepted, and in execute it uses
// forwarding from any register write made since that read.
// A word is registered into execute when accepted and its result into the
// result register; an LW goes through load write-back for its data memory read.
// Throughput: one word per cycle while out_ready is high; the word after an
// LW waits in execute while the load is in write-back, since the two share
// the one result register and the register file write port.
// Configuration writes (index 0 start_address, 1 data_base) are taken on any
// cycle and belong to idle periods; start_address also loads the pc.
// rst (synchronous) clears the register file through per-register valid bits
// at once, loads the pc from the reset start_address and sets running; data
// memory contents stay undefined until written.
// When out_ready is low the result register holds; an LW still moves on to
// write-back, and one more word may sit in execute, after which in_ready drops.
`default_nettype none
module mips_subset_execute (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [31:0]               instruction_word,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [31:0]                    next_pc,
  output logic                           halted,
  output logic                           reg_written,
  output logic [4:0]                     reg_index,
  output logic [31:0]                    reg_value,
  output logic                           store_done,
  output logic [31:0]                    store_address,
  output logic [31:0]                    store_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [mse_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data
);
  import mse_pkg::*;

  // configuration and architectural state
  logic [31:0] data_base;
  logic [31:0] pc;
  logic        running;

  // register file ram with reset valid bits
  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] rf_q_s, rf_q_t;
  logic        rf_vld_s, rf_vld_t;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  // data memory ram
  logic [31:0]        dmem [DATA_WORDS];
  logic [31:0]        dm_q;
  logic               dm_we, dm_re;
  logic [DATA_AW-1:0] dm_addr;

  // execute stage
  logic        e_valid;
  logic [31:0] e_word;
  logic        fs_v, ft_v;
  logic [31:0] fs_val, ft_val;

  // load write-back stage
  logic        m_valid;
  logic [4:0]  m_rt;
  logic [31:0] m_pc;
  logic        m_inrange;

  logic accept, out_free, e_done, e_out, m_done;

  // decode
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, zimm, vs, vt, pc4;
  logic [31:0] mem_addr, mem_off;
  logic [29:0] mem_ix;
  logic        mem_inrange;

  // execute results
  logic [31:0] pc_new;
  logic        run_new;
  logic        wr;
  logic [4:0]  widx;
  logic [31:0] wval;
  logic        st;
  logic        e_load;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid || out_ready;
  assign e_done   = e_valid && !m_valid && (e_load || out_free);
  assign e_out    = e_done && !e_load;
  assign m_done   = m_valid && out_free;
  assign in_ready = !e_valid || e_done;
  assign accept   = in_valid && in_ready;

  assign op   = e_word[31:26];
  assign rs   = e_word[25:21];
  assign rt   = e_word[20:16];
  assign rd   = e_word[15:11];
  assign sh   = e_word[10:6];
  assign fn   = e_word[5:0];
  assign imm  = e_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};
  assign pc4  = pc + 32'd4;

  // operands: forwarded write since the read, else ram data, else reset zero
  assign vs = fs_v ? fs_val : (rf_vld_s ? rf_q_s : 32'h0);
  assign vt = ft_v ? ft_val : (rf_vld_t ? rf_q_t : 32'h0);

  assign mem_addr    = vs + simm;
  assign mem_off     = mem_addr - data_base;
  assign mem_ix      = mem_off[31:2];
  assign mem_inrange = {2'b00, mem_ix} < 32'(DATA_WORDS);

  always_comb begin
    pc_new  = pc;
    run_new = running;
    wr      = 1'b0;
    widx    = 5'd0;
    wval    = 32'h0;
    st      = 1'b0;
    e_load  = 1'b0;
    if (running) begin
      if (op == OP_RTYPE && rd == 5'd0 && sh == 5'd0 && fn == FN_SLL) begin
        // halt word
        run_new = 1'b0;
      end else begin
        unique case (op)
          OP_ADDIU: begin
            wr = 1'b1; widx = rt; wval = vs + simm; pc_new = pc4;
          end
          OP_ANDI: begin
            wr = 1'b1; widx = rt; wval = vs & zimm; pc_new = pc4;
          end
          OP_LUI: begin
            wr = 1'b1; widx = rt; wval = {imm, 16'h0000}; pc_new = pc4;
          end
          OP_ORI: begin
            wr = 1'b1; widx = rt; wval = vs | zimm; pc_new = pc4;
          end
          OP_SLTIU: begin
            wr = 1'b1; widx = rt; wval = {31'h0, vs < simm}; pc_new = pc4;
          end
          OP_LW: begin
            // register write happens in the load write-back stage
            e_load = 1'b1; pc_new = pc4;
          end
          OP_SW: begin
            st = mem_inrange; pc_new = pc4;
          end
          OP_BEQ: pc_new = (vs == vt) ? pc4 + {simm[29:0], 2'b00} : pc4;
          OP_BNE: pc_new = (vs != vt) ? pc4 + {simm[29:0], 2'b00} : pc4;
          OP_RTYPE: begin
            unique case (fn)
              FN_ADDU: begin wr = 1'b1; widx = rd; wval = vs + vt;    pc_new = pc4; end
              FN_AND:  begin wr = 1'b1; widx = rd; wval = vs & vt;    pc_new = pc4; end
              FN_NOR:  begin wr = 1'b1; widx = rd; wval = ~(vs | vt); pc_new = pc4; end
              FN_OR:   begin wr = 1'b1; widx = rd; wval = vs | vt;    pc_new = pc4; end
              FN_SLTU: begin
                wr = 1'b1; widx = rd; wval = {31'h0, vs < vt}; pc_new = pc4;
              end
              FN_SLL:  begin wr = 1'b1; widx = rd; wval = vt << sh;   pc_new = pc4; end
              FN_SRL:  begin wr = 1'b1; widx = rd; wval = vt >> sh;   pc_new = pc4; end
              FN_SUBU: begin wr = 1'b1; widx = rd; wval = vs - vt;    pc_new = pc4; end
              FN_JR:   pc_new = vs;
              default: ; // unknown function leaves everything as it was
            endcase
          end
          OP_J: pc_new = {4'h0, e_word[25:0], 2'b00};
          OP_JAL: begin
            wr = 1'b1; widx = LINK_REG; wval = pc + 32'd8;
            pc_new = {4'h0, e_word[25:0], 2'b00};
          end
          default: begin
            pc_new  = pc - 32'd4;
            run_new = 1'b0;
          end
        endcase
      end
    end
    if (widx == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      widx = 5'd0;
      wval = 32'h0;
    end
  end

  // one register file write port, shared by execute and load write-back
  always_comb begin
    if (m_done) begin
      rf_we = m_rt != 5'd0;
      rf_wa = m_rt;
      rf_wd = m_inrange ? dm_q : 32'h0;
    end else begin
      rf_we = e_out && wr;
      rf_wa = widx;
      rf_wd = wval;
    end
  end

  assign dm_we   = e_done && st;
  assign dm_re   = e_done && e_load && mem_inrange;
  assign dm_addr = mem_ix[DATA_AW-1:0];

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (accept) begin
      rf_q_s <= rf[instruction_word[25:21]];
      rf_q_t <= rf[instruction_word[20:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_addr] <= vt;
    end
    if (dm_re) begin
      dm_q <= dmem[dm_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_wa] <= 1'b1;
    end
  end

  // valid bits and forwarding, sampled along with the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_v <= 1'b0;
      ft_v <= 1'b0;
    end else if (accept) begin
      rf_vld_s <= rf_valid[instruction_word[25:21]];
      rf_vld_t <= rf_valid[instruction_word[20:16]];
      fs_v     <= rf_we && rf_wa == instruction_word[25:21];
      ft_v     <= rf_we && rf_wa == instruction_word[20:16];
      fs_val   <= rf_wd;
      ft_val   <= rf_wd;
    end else if (e_valid && rf_we) begin
      // a load write-back lands while this word waits
      if (rf_wa == rs) begin
        fs_v   <= 1'b1;
        fs_val <= rf_wd;
      end
      if (rf_wa == rt) begin
        ft_v   <= 1'b1;
        ft_val <= rf_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (accept) begin
      e_valid <= 1'b1;
    end else if (e_done) begin
      e_valid <= 1'b0;
    end
    if (accept) begin
      e_word <= instruction_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (e_done && e_load) begin
      m_valid <= 1'b1;
    end else if (m_done) begin
      m_valid <= 1'b0;
    end
    if (e_done && e_load) begin
      m_rt      <= rt;
      m_pc      <= pc_new;
      m_inrange <= mem_inrange;
    end
  end

  // start_address only matters as the value loaded into the pc
  always_ff @(posedge clk) begin
    if (rst) begin
      data_base     <= BASE_RESET;
      pc            <= START_RESET;
      running       <= 1'b1;
    end else begin
      if (e_done) begin
        pc      <= pc_new;
        running <= run_new;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_ADDRESS: begin
            pc            <= cfg_data;
          end
          CFG_DATA_BASE: data_base <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= e_out || m_done;
    end
    if (m_done) begin
      next_pc       <= m_pc;
      halted        <= 1'b0;
      reg_written   <= m_rt != 5'd0;
      reg_index     <= m_rt;
      reg_value     <= (m_rt != 5'd0 && m_inrange) ? dm_q : 32'h0;
      store_done    <= 1'b0;
      store_address <= 32'h0;
      store_value   <= 32'h0;
    end else if (e_out) begin
      next_pc       <= pc_new;
      halted        <= !run_new;
      reg_written   <= wr;
      reg_index     <= widx;
      reg_value     <= wval;
      store_done    <= st;
      store_address <= st ? mem_addr : 32'h0;
      store_value   <= st ? vt : 32'h0;
    end
  end

endmodule
`default_nettype wire
